// ===== hdl/sslu_pkg.sv =====
// Package with the types and constants of the sensor slot lookup and insert block.
package sslu_pkg;

    localparam logic [7:0] TYPE_WILDCARD = 8'd63;
    localparam logic [7:0] TYPE_EMPTY    = 8'd0;
    localparam int         ID_W          = 8;
    localparam int         TYPE_W        = 8;
    localparam int         SLOT_W        = 4;

    typedef enum logic [2:0] {
        ST_FOUND    = 3'd0,
        ST_FILLED   = 3'd1,
        ST_ADDED    = 3'd2,
        ST_MISMATCH = 3'd3,
        ST_FULL     = 3'd4
    } status_t;

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_SCAN = 3'b010,
        S_DONE = 3'b100
    } state_t;

endpackage

// ===== hdl/sensor_slot_lookup_insert.sv =====
// Sensor slot table: lookup of a sensor id with insert on a miss, held in one memory.
//
//   channel   direction  tdata fields (lowest bit first)       meaning
//   s_axis    in         sensor_id[7:0], sensor_type[15:8]     one lookup request
//   m_axis    out        slot[3:0], status[6:4], zero[7]       one result per request
//
// When the table holds no slot yet, an item is appended at once without a
// scan. Otherwise the scan reads one slot per cycle from the synchronous table
// memory and stops at the first hit or at the fill count.
// Reset clears the state machine, the fill count and the output valid flag;
// slots at or above the fill count are treated as empty, so no clearing pass runs.
// A new item is taken only in the idle state; a finished result waits in the
// S_DONE state until the output register is free, and the output register
// holds its item while m_tready is low.
module sensor_slot_lookup_insert
    import sslu_pkg::*;
#(
    parameter int TABLE_SLOTS = 16
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // sensor_id [7:0], sensor_type [15:8]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata    // slot [3:0], status [6:4], zero [7]
);

    // Index width for the memory and count width that can hold TABLE_SLOTS itself.
    localparam int IDX_W = (TABLE_SLOTS > 1) ? $clog2(TABLE_SLOTS) : 1;
    localparam int CNT_W = $clog2(TABLE_SLOTS + 1);
    localparam logic [CNT_W-1:0] SLOTS_CNT = CNT_W'(TABLE_SLOTS);

    // Each memory word holds the type in the upper byte and the id in the lower.
    logic [TYPE_W+ID_W-1:0] table_mem [TABLE_SLOTS];
    logic [TYPE_W+ID_W-1:0] rd_data;
    logic [IDX_W-1:0]       rd_addr;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [TYPE_W+ID_W-1:0] wr_data;

    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    used_reg, used_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [TYPE_W-1:0]   type_reg, type_next;
    logic [SLOT_W-1:0]   slot_reg, slot_next;
    status_t             status_reg, status_next;
    logic                m_valid_reg, m_valid_next;
    logic [7:0]          m_data_reg, m_data_next;

    logic [ID_W-1:0]     in_id;
    logic [TYPE_W-1:0]   in_type;
    logic [ID_W-1:0]     rd_id;
    logic [TYPE_W-1:0]   rd_type;
    logic                hit;
    logic [CNT_W-1:0]    scan_inc;
    logic [IDX_W+SLOT_W-1:0] scan_wide;
    logic [IDX_W+SLOT_W-1:0] used_wide;
    logic                out_free;

    assign in_id    = s_tdata[ID_W-1:0];
    assign in_type  = s_tdata[ID_W+TYPE_W-1:ID_W];
    assign rd_id    = rd_data[ID_W-1:0];
    assign rd_type  = rd_data[ID_W+TYPE_W-1:ID_W];
    assign hit      = (rd_type != TYPE_EMPTY) && (rd_id == id_reg);
    assign scan_inc = scan_reg + 1'b1;
    assign out_free = !m_valid_reg || m_tready;

    // Slot numbers are reported modulo 16.
    assign scan_wide = {{SLOT_W{1'b0}}, scan_reg[IDX_W-1:0]};
    assign used_wide = {{SLOT_W{1'b0}}, used_reg[IDX_W-1:0]};

    assign s_tready = (state_reg == S_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            table_mem[wr_addr] <= wr_data;
        end
        rd_data <= table_mem[rd_addr];
    end

    always_comb
    begin
        state_next   = state_reg;
        used_next    = used_reg;
        scan_next    = scan_reg;
        id_next      = id_reg;
        type_next    = type_reg;
        slot_next    = slot_reg;
        status_next  = status_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        rd_addr      = scan_reg[IDX_W-1:0];
        wr_en        = 1'b0;
        wr_addr      = scan_reg[IDX_W-1:0];
        wr_data      = {type_reg, id_reg};

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    id_next   = in_id;
                    type_next = in_type;
                    scan_next = '0;
                    rd_addr   = '0;
                    if (used_reg == '0)
                    begin
                        // Empty table: the miss is known at once and the item is appended.
                        wr_en       = 1'b1;
                        wr_addr     = '0;
                        wr_data     = {in_type, in_id};
                        used_next   = CNT_W'(1);
                        slot_next   = '0;
                        status_next = ST_ADDED;
                        state_next  = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SCAN;
                    end
                end
            end

            S_SCAN:
            begin
                if (hit)
                begin
                    slot_next   = scan_wide[SLOT_W-1:0];
                    state_next  = S_DONE;
                    if (rd_type == type_reg)
                    begin
                        status_next = ST_FOUND;
                    end
                    else if (rd_type == TYPE_WILDCARD)
                    begin
                        // A stored wildcard takes the incoming type, zero included.
                        wr_en       = 1'b1;
                        wr_data     = {type_reg, rd_id};
                        status_next = ST_FILLED;
                    end
                    else if (type_reg == TYPE_WILDCARD)
                    begin
                        status_next = ST_FOUND;
                    end
                    else
                    begin
                        slot_next   = '0;
                        status_next = ST_MISMATCH;
                    end
                end
                else if (scan_inc < used_reg)
                begin
                    scan_next = scan_inc;
                    rd_addr   = scan_inc[IDX_W-1:0];
                end
                else
                begin
                    state_next = S_DONE;
                    if (used_reg < SLOTS_CNT)
                    begin
                        wr_en       = 1'b1;
                        wr_addr     = used_reg[IDX_W-1:0];
                        used_next   = used_reg + 1'b1;
                        slot_next   = used_wide[SLOT_W-1:0];
                        status_next = ST_ADDED;
                    end
                    else
                    begin
                        slot_next   = '0;
                        status_next = ST_FULL;
                    end
                end
            end

            S_DONE:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, status_reg, slot_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            used_reg    <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            used_reg    <= used_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_reg   <= scan_next;
        id_reg     <= id_next;
        type_reg   <= type_next;
        slot_reg   <= slot_next;
        status_reg <= status_next;
        m_data_reg <= m_data_next;
    end

endmodule

// ===== sim/tb_sensor_slot_lookup_insert.sv =====
// Self-checking testbench for the sensor slot lookup and insert table.
`timescale 1ns / 100ps

module tb_sensor_slot_lookup_insert;
    import sslu_pkg::*;

    localparam int TABLE_SLOTS  = 16;
    localparam int RANDOM_ITEMS = 800;
    // The slowest correct run pays the worst sender gap, a full table scan
    // and the worst receiver stall on every item.
    // This limit lies well above that.
    localparam int CYCLE_LIMIT  = 400000;
    // This drain time runs after the last expected result has been
    // checked.
    localparam int DRAIN_CYCLES = 40;

    // Printable type codes that are used by the directed items.
    localparam logic [7:0] TYPE_T = "T";
    localparam logic [7:0] TYPE_H = "H";
    localparam logic [7:0] TYPE_P = "P";

    // This is one expected result: the table slot and the outcome of the lookup.
    typedef struct packed {
        logic [SLOT_W-1:0] slot;
        status_t           status;
    } slot_result_t;

    // The board keeps its own copy of the sensor table and predicts the result
    // of every accepted request. The expected results wait in arrival order.
    class slot_table_board;
        logic [ID_W-1:0]   slot_id [TABLE_SLOTS];
        logic [TYPE_W-1:0] slot_type [TABLE_SLOTS];
        int unsigned       fill_count;
        slot_result_t      expected_q [$];
        int unsigned       errors;
        int unsigned       checked;
        int unsigned       status_count [5];

        function new();
            foreach (slot_type[i])
            begin
                slot_type[i] = TYPE_EMPTY;
                slot_id[i]   = '0;
            end
            foreach (status_count[i])
                status_count[i] = 0;
            fill_count = 0;
            errors     = 0;
            checked    = 0;
        endfunction

        function void note_request(input logic [ID_W-1:0] id, input logic [TYPE_W-1:0] ty);
            slot_result_t r;
            int           hit_slot;
            hit_slot = -1;
            // The lowest slot with a nonzero type and a matching id wins.
            for (int i = 0; i < TABLE_SLOTS; i++)
                if (hit_slot < 0 && slot_type[i] != TYPE_EMPTY && slot_id[i] == id)
                    hit_slot = i;
            if (hit_slot >= 0)
            begin
                r.slot = SLOT_W'(hit_slot);
                if (slot_type[hit_slot] == ty)
                    r.status = ST_FOUND;
                else if (slot_type[hit_slot] == TYPE_WILDCARD)
                begin
                    // A stored wildcard takes the incoming type, even zero.
                    slot_type[hit_slot] = ty;
                    r.status = ST_FILLED;
                end
                else if (ty == TYPE_WILDCARD)
                    r.status = ST_FOUND;
                else
                begin
                    r.slot   = '0;
                    r.status = ST_MISMATCH;
                end
            end
            else if (fill_count < TABLE_SLOTS)
            begin
                // On a miss the request is appended. A zero type uses up the
                // slot, but that slot never matches later.
                r.slot = SLOT_W'(fill_count);
                slot_id[fill_count]   = id;
                slot_type[fill_count] = ty;
                fill_count++;
                r.status = ST_ADDED;
            end
            else
            begin
                r.slot   = '0;
                r.status = ST_FULL;
            end
            expected_q.push_back(r);
        endfunction

        function void check_result(input logic [7:0] data);
            slot_result_t      want;
            logic [SLOT_W-1:0] got_slot;
            status_t           got_status;
            got_slot   = data[3:0];
            got_status = status_t'(data[6:4]);
            if (expected_q.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result item: expected none, actual slot %0d status %0d",
                         $time, got_slot, got_status);
                return;
            end
            want = expected_q.pop_front();
            checked++;
            status_count[want.status]++;
            if (got_slot !== want.slot)
            begin
                errors++;
                $display("%0t: slot mismatch: expected %0d, actual %0d",
                         $time, want.slot, got_slot);
            end
            if (got_status !== want.status)
            begin
                errors++;
                $display("%0t: status mismatch: expected %0d, actual %0d",
                         $time, want.status, got_status);
            end
        endfunction
    endclass

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;   // sensor_id [7:0], sensor_type [15:8]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // slot [3:0], status [6:4], zero [7]

    slot_table_board board;
    bit              no_idle = 1'b0;
    int unsigned     cycle_count = 0;

    sensor_slot_lookup_insert #(
        .TABLE_SLOTS (TABLE_SLOTS)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // This watchdog stops a run that hangs.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycle_count);
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Each side draws a random wait from draw_wait before each item. In the no-idle
    // stretches both sides run at full rate.
    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, 19);
    endfunction

    // This task offers one request and waits until the block accepts it.
    // The valid signal is only lowered when a gap follows. A back-to-back
    // item keeps valid high, so valid is never lowered and raised in the
    // same time step.
    task automatic send_request(input logic [ID_W-1:0] id, input logic [TYPE_W-1:0] ty);
        int gap;
        gap = draw_wait();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {ty, id};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        board.note_request(id, ty);
    endtask

    // The receiver stalls at random before each result. The output values
    // are sampled at the edge, before the block updates them.
    initial
    begin
        int gap;
        wait (rst_n === 1'b1);
        forever
        begin
            gap = draw_wait();
            if (gap > 0)
            begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            m_tready <= 1'b1;
            @(posedge clk);
            while (!m_tvalid)
                @(posedge clk);
            board.check_result(m_tdata);
        end
    end

    initial
    begin
        int                n;
        int                pick;
        int                roll;
        logic [ID_W-1:0]   id;
        logic [TYPE_W-1:0] ty;
        logic [TYPE_W-1:0] known_type;

        board = new();
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. The first case is a wildcard append that is then
        // filled, hit with the same type, hit with a wildcard, and hit with
        // a different type.
        send_request(8'h00, TYPE_WILDCARD);
        send_request(8'h00, TYPE_T);
        send_request(8'h00, TYPE_T);
        send_request(8'h00, TYPE_WILDCARD);
        send_request(8'h00, TYPE_H);
        // All-ones fields, then a hit with a zero type, which is a mismatch.
        send_request(8'hFF, 8'hFF);
        send_request(8'hFF, TYPE_EMPTY);
        // An append with type zero uses up a slot that never matches, so the
        // same id is appended again.
        send_request(8'h55, TYPE_EMPTY);
        send_request(8'h55, TYPE_EMPTY);
        // A wildcard that is filled with zero goes dead. The next request
        // appends a fresh slot instead of reusing the dead one.
        send_request(8'hAA, TYPE_WILDCARD);
        send_request(8'hAA, TYPE_EMPTY);
        send_request(8'hAA, TYPE_P);
        send_request(8'hAA, TYPE_P);
        // A stored wildcard that is hit by a wildcard counts as equal types.
        send_request(8'h0F, TYPE_WILDCARD);
        send_request(8'h0F, TYPE_WILDCARD);
        // The remaining slots are filled with wildcards, which the random part
        // fills in later. Then a miss finds the table full.
        for (n = 0; n < 9; n++)
            send_request(8'h10 + 8'(n) * 8'h11, TYPE_WILDCARD);
        send_request(8'h3C, TYPE_T);

        // Random part. Most requests reuse ids that are already in the table,
        // so that the hit paths stay busy. The rest are random ids, which
        // mostly miss on the full table.
        for (n = 0; n < RANDOM_ITEMS; n++)
        begin
            no_idle = ((n / 100) % 4) == 2;
            if ($urandom_range(0, 99) < 65)
            begin
                pick       = $urandom_range(0, TABLE_SLOTS - 1);
                id         = board.slot_id[pick];
                known_type = board.slot_type[pick];
            end
            else
            begin
                id         = ID_W'($urandom_range(0, 255));
                known_type = TYPE_W'($urandom_range(1, 255));
            end
            roll = $urandom_range(0, 99);
            if (roll < 25)
                ty = TYPE_WILDCARD;
            else if (roll < 35)
                ty = TYPE_EMPTY;
            else if (roll < 65)
                ty = known_type;
            else
                ty = TYPE_W'($urandom_range(0, 255));
            send_request(id, ty);
        end
        no_idle = 1'b0;
        s_tvalid <= 1'b0;

        while (board.expected_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Checked %0d lookups against the table prediction, %0d slots appended.",
                 board.checked, board.fill_count);
        $display("Outcomes: %0d found, %0d filled, %0d added, %0d type clashes, %0d table full.",
                 board.status_count[ST_FOUND], board.status_count[ST_FILLED],
                 board.status_count[ST_ADDED], board.status_count[ST_MISMATCH],
                 board.status_count[ST_FULL]);
        if (board.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

// ===== files.f =====
hdl/sslu_pkg.sv
hdl/sensor_slot_lookup_insert.sv
sim/tb_sensor_slot_lookup_insert.sv
